// ===== rtl/b2b_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_pkg: shared types and constants for the burst to beat splitter
// Transfer table sizes, field widths, command codes and the item and result
// records that travel between the splitter's modules.
// ----------------------------------------------------------------------------
package b2b_pkg;

	// table sizes
	localparam int NUM_XFERS  = 16;
	localparam int NUM_BEATS  = 16;
	localparam int BEAT_BYTES = 64;

	// field widths
	localparam int TAG_W  = 4;
	localparam int SLOT_W = 4;
	localparam int QIDX_W = $clog2(NUM_XFERS);
	localparam int ADDR_W = 48;
	localparam int SIZE_W = 16;
	localparam int CNT_W  = 7;
	localparam int SKIP_W = $clog2(BEAT_BYTES);
	localparam int TICK_W = 64;
	localparam int PEND_W = 5;
	localparam int FILL_W = 5;
	localparam int WIN_W  = 5;
	localparam int CMD_W  = 3;

	localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(8);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NUM_XFERS);

	// command codes
	localparam logic [CMD_W-1:0] CMD_NEW    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ANSWER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DENY   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GRANT  = 3'd4;

	// result kinds
	localparam logic KIND_BEAT = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TAG_W-1:0]  req_tag;
		logic [ADDR_W-1:0] req_addr;
		logic [SIZE_W-1:0] req_bytes;
		logic              req_write;
		logic [SIZE_W-1:0] req_delay;
		logic [SLOT_W-1:0] answered_beat;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] beat_addr;
		logic [CNT_W-1:0]  beat_bytes;
		logic              beat_write;
		logic [SLOT_W-1:0] beat_slot;
		logic [TAG_W-1:0]  done_tag;
		logic [SIZE_W-1:0] beat_offset;
		logic [SKIP_W-1:0] beat_skip;
		logic [CNT_W-1:0]  beat_valid_bytes;
	} result_t;

endpackage

// ===== rtl/b2b_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_engine: transfer table, order queue and beat slot tracking
// Applies one registered command per cycle while fire is high: queues new
// transfers, cuts the head transfer into beats on a tick, retires answered
// beats, reports finished transfers and blocks issue on deny until grant.
// ----------------------------------------------------------------------------
module b2b_engine import b2b_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata,
	input  logic             fire,
	input  item_t            item,
	output logic             res_vld,
	output result_t          res
);

	// control state
	logic [TICK_W-1:0]    tick_q;
	logic                 blocked_q;
	logic [QIDX_W-1:0]    head_q;
	logic [FILL_W-1:0]    fill_q;
	logic [NUM_BEATS-1:0] busy_q;
	logic [PEND_W-1:0]    beats_out_q;
	logic [WIN_W-1:0]     win_q;

	// transfer table and queue, no reset
	logic [TAG_W-1:0]  oq_q          [NUM_XFERS];
	logic [ADDR_W-1:0] slot_addr_q   [NUM_XFERS];
	logic [SIZE_W-1:0] slot_total_q  [NUM_XFERS];
	logic [SIZE_W-1:0] slot_issued_q [NUM_XFERS];
	logic [PEND_W-1:0] slot_pend_q   [NUM_XFERS];
	logic              slot_wr_q     [NUM_XFERS];
	logic [TICK_W-1:0] slot_ready_q  [NUM_XFERS];
	logic [TAG_W-1:0]  parent_q      [NUM_BEATS];

	logic              is_new, is_tick, is_answer;
	logic [TAG_W-1:0]  head_tag, par_tag, rd_tag;
	logic [ADDR_W-1:0] s_addr;
	logic [SIZE_W-1:0] s_total, s_issued;
	logic [PEND_W-1:0] s_pend, pend_dec;
	logic              s_wr;
	logic [TICK_W-1:0] s_ready;
	logic              can_try, exhausted, ready_ok, free_found;
	logic [SLOT_W-1:0] free_slot;
	logic [ADDR_W-1:0] addr;
	logic [SKIP_W-1:0] skip;
	logic [SIZE_W-1:0] remain, new_issued;
	logic [CNT_W-1:0]  cnt_max, cnt;
	logic              do_new, do_issue, do_pop, do_retire, do_done;
	logic [QIDX_W-1:0] tail;

	// command decode
	assign is_new    = (item.cmd == CMD_NEW);
	assign is_tick   = (item.cmd == CMD_TICK);
	assign is_answer = (item.cmd == CMD_ANSWER);

	// table read at the head transfer or at the answered beat's parent
	assign head_tag = oq_q[head_q];
	assign par_tag  = parent_q[item.answered_beat];
	assign rd_tag   = is_tick ? head_tag : par_tag;
	assign s_addr   = slot_addr_q[rd_tag];
	assign s_total  = slot_total_q[rd_tag];
	assign s_issued = slot_issued_q[rd_tag];
	assign s_pend   = slot_pend_q[rd_tag];
	assign s_wr     = slot_wr_q[rd_tag];
	assign s_ready  = slot_ready_q[rd_tag];

	// issue conditions
	assign can_try   = !blocked_q && (fill_q != '0) && (beats_out_q < win_q);
	assign exhausted = (s_issued >= s_total);
	assign ready_ok  = !(s_ready > tick_q);

	// lowest free beat slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = NUM_BEATS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	// beat cut at the next aligned boundary
	assign addr       = s_addr + ADDR_W'(s_issued);
	assign skip       = addr[SKIP_W-1:0];
	assign remain     = s_total - s_issued;
	assign cnt_max    = CNT_W'(BEAT_BYTES) - CNT_W'(skip);
	assign cnt        = (remain < SIZE_W'(cnt_max)) ? CNT_W'(remain) : cnt_max;
	assign new_issued = s_issued + SIZE_W'(cnt);

	assign do_new    = fire && is_new && (item.req_bytes != '0) && (fill_q != FILL_FULL);
	assign do_issue  = fire && is_tick && can_try && !exhausted && ready_ok && free_found;
	assign do_pop    = fire && is_tick && can_try &&
	                   (exhausted || (do_issue && (new_issued >= s_total)));
	assign do_retire = fire && is_answer && busy_q[item.answered_beat];
	assign pend_dec  = (s_pend != '0) ? s_pend - PEND_W'(1) : '0;
	assign do_done   = do_retire && (pend_dec == '0) && (s_issued == s_total);
	assign tail      = head_q + fill_q[QIDX_W-1:0];

	// result record
	always_comb begin
		res     = '0;
		res_vld = do_issue || do_done;
		if (do_issue) begin
			res.kind             = KIND_BEAT;
			res.beat_addr        = s_wr ? addr : {addr[ADDR_W-1:SKIP_W], SKIP_W'(0)};
			res.beat_bytes       = s_wr ? cnt : CNT_W'(BEAT_BYTES);
			res.beat_write       = s_wr;
			res.beat_slot        = free_slot;
			res.done_tag         = rd_tag;
			res.beat_offset      = s_issued;
			res.beat_skip        = s_wr ? '0 : skip;
			res.beat_valid_bytes = cnt;
		end else if (do_done) begin
			res.kind     = KIND_DONE;
			res.done_tag = rd_tag;
		end
	end

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			blocked_q   <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
			busy_q      <= '0;
			beats_out_q <= '0;
			win_q       <= WIN_RESET;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (fire && is_tick) begin
				tick_q <= tick_q + TICK_W'(1);
			end
			if (fire && (item.cmd == CMD_DENY)) begin
				blocked_q <= 1'b1;
			end
			if (fire && (item.cmd == CMD_GRANT)) begin
				blocked_q <= 1'b0;
			end
			if (do_new) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (do_pop) begin
				head_q <= head_q + QIDX_W'(1);
				fill_q <= fill_q - FILL_W'(1);
			end
			if (do_issue) begin
				busy_q[free_slot] <= 1'b1;
				beats_out_q       <= beats_out_q + PEND_W'(1);
			end
			if (do_retire) begin
				busy_q[item.answered_beat] <= 1'b0;
				if (beats_out_q != '0) begin
					beats_out_q <= beats_out_q - PEND_W'(1);
				end
			end
		end
	end

	// transfer table and queue writes
	always_ff @(posedge clk) begin
		if (do_new) begin
			slot_addr_q[item.req_tag]   <= item.req_addr;
			slot_total_q[item.req_tag]  <= item.req_bytes;
			slot_issued_q[item.req_tag] <= '0;
			slot_pend_q[item.req_tag]   <= '0;
			slot_wr_q[item.req_tag]     <= item.req_write;
			slot_ready_q[item.req_tag]  <= tick_q + TICK_W'(item.req_delay);
			oq_q[tail]                  <= item.req_tag;
		end
		if (do_issue) begin
			slot_issued_q[rd_tag] <= new_issued;
			slot_pend_q[rd_tag]   <= s_pend + PEND_W'(1);
			parent_q[free_slot]   <= rd_tag;
		end
		if (do_retire) begin
			slot_pend_q[rd_tag] <= pend_dec;
		end
	end

endmodule

// ===== rtl/b2b_result_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_result_reg: output register for the result channel
// Holds one result until the downstream side takes it and tells the engine
// when a new result may be loaded.
// ----------------------------------------------------------------------------
module b2b_result_reg import b2b_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	input  logic    res_stall,
	output logic    free,
	output logic    res_valid,
	output result_t dout
);

	logic    vld_q;
	result_t data_q;

	// room for a new result when empty or being taken this cycle
	assign free      = !vld_q || !res_stall;
	assign res_valid = vld_q;
	assign dout      = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!res_stall) begin
			vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// ===== rtl/burst_to_beat_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_to_beat_splitter: cuts memory transfers into 64-byte aligned beats
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall  cmd, req_*, answered_beat
//   result    out        res_valid / res_stall    kind, beat_*, done_tag
//   config    in         cfg_we                   cfg_wdata (beat window)
//
// One command per cycle unless stalled: a transfer into the input register,
// then the engine applies it once the output register has room and loads any
// result into the output register, which drives the outputs.
// Reset clears the queue, beat slots and tick count; the window resets to 8.
// res_stall holds the output register and backs up into item_stall.
// ----------------------------------------------------------------------------
module burst_to_beat_splitter import b2b_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [WIN_W-1:0]  cfg_wdata,
	// item channel
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [TAG_W-1:0]  req_tag,
	input  logic [ADDR_W-1:0] req_addr,
	input  logic [SIZE_W-1:0] req_bytes,
	input  logic              req_write,
	input  logic [SIZE_W-1:0] req_delay,
	input  logic [SLOT_W-1:0] answered_beat,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic              kind,
	output logic [ADDR_W-1:0] beat_addr,
	output logic [CNT_W-1:0]  beat_bytes,
	output logic              beat_write,
	output logic [SLOT_W-1:0] beat_slot,
	output logic [TAG_W-1:0]  done_tag,
	output logic [SIZE_W-1:0] beat_offset,
	output logic [SKIP_W-1:0] beat_skip,
	output logic [CNT_W-1:0]  beat_valid_bytes
);

	logic    vld_s1;
	item_t   item_s1;
	logic    fire, free, accept, res_vld;
	result_t res, dout;

	// the registered command runs once the output register has room
	assign fire       = vld_s1 && free;
	assign item_stall = vld_s1 && !fire;
	assign accept     = item_valid && !item_stall;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd           <= cmd;
			item_s1.req_tag       <= req_tag;
			item_s1.req_addr      <= req_addr;
			item_s1.req_bytes     <= req_bytes;
			item_s1.req_write     <= req_write;
			item_s1.req_delay     <= req_delay;
			item_s1.answered_beat <= answered_beat;
		end
	end

	b2b_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res_vld   (res_vld),
		.res       (res)
	);

	b2b_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_vld),
		.din       (res),
		.res_stall (res_stall),
		.free      (free),
		.res_valid (res_valid),
		.dout      (dout)
	);

	// result fields to ports
	assign kind             = dout.kind;
	assign beat_addr        = dout.beat_addr;
	assign beat_bytes       = dout.beat_bytes;
	assign beat_write       = dout.beat_write;
	assign beat_slot        = dout.beat_slot;
	assign done_tag         = dout.done_tag;
	assign beat_offset      = dout.beat_offset;
	assign beat_skip        = dout.beat_skip;
	assign beat_valid_bytes = dout.beat_valid_bytes;

endmodule
